// ----- design/encoder_angle_velocity_tracker_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the encoder angle/velocity tracker
// Shared helpers for concurrent checks clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef ENCODER_ANGLE_VELOCITY_TRACKER_TOP_DEFINES_SVH
`define ENCODER_ANGLE_VELOCITY_TRACKER_TOP_DEFINES_SVH

// property must hold at every clock edge out of reset
`define EVAT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define EVAT_ASSERT_NEVER(label, cond, msg) \
  `EVAT_ASSERT(label, !(cond), msg)

`endif

// ----- design/evat_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evat_pkg
// Widths, constants and shared types of the encoder angle/velocity tracker.
// ----------------------------------------------------------------------------
package evat_pkg;

  // field widths
  localparam int WORD_BITS     = 16;
  localparam int ANGLE_BITS    = 12;
  localparam int TS_BITS       = 32;
  localparam int FT_BITS       = 16;
  localparam int TURN_BITS     = 24;
  localparam int POS_BITS      = ANGLE_BITS + TURN_BITS;
  localparam int VEL_BITS      = 30;
  localparam int VEL_FRAC_BITS = 8;

  // stream packing
  localparam int IN_TDATA_BITS  = 48;
  localparam int OUT_TDATA_BITS = 104;
  localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - VEL_BITS - POS_BITS - TURN_BITS - ANGLE_BITS;

  // angle arithmetic
  localparam int HALF_TURN  = 1 << (ANGLE_BITS - 1);
  localparam int FULL_TURN  = 1 << ANGLE_BITS;
  localparam int DELTA_BITS = ANGLE_BITS + 2;

  // velocity scaling: delta * 1000 ms/s, then fraction bits
  localparam int MS_PER_S    = 1000;
  localparam int MSP_BITS    = ANGLE_BITS + 10;
  localparam int NUM_BITS    = MSP_BITS + VEL_FRAC_BITS;

  // shared divider: dividend/divisor with quotient known below 2^QUOT_BITS
  localparam int QUOT_BITS     = VEL_BITS + 1;
  localparam int DIVISOR_BITS  = TS_BITS + 1;
  localparam int DIVIDEND_BITS = 2 * QUOT_BITS;
  localparam int DIV_CNT_BITS  = $clog2(QUOT_BITS);

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- design/evat_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evat_div
// Shared radix-2 restoring divider, one quotient bit per cycle. The caller
// guarantees the quotient fits QUOT_BITS, so the upper dividend half is
// preloaded as the partial remainder.
// ----------------------------------------------------------------------------
module evat_div (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [evat_pkg::DIVIDEND_BITS-1:0]    dividend,
  input  logic [evat_pkg::DIVISOR_BITS-1:0]     divisor,
  output evat_pkg::div_stat_t                   stat,
  output logic [evat_pkg::QUOT_BITS-1:0]        quotient
);

  localparam int QB = evat_pkg::QUOT_BITS;
  localparam int DB = evat_pkg::DIVISOR_BITS;
  localparam logic [evat_pkg::DIV_CNT_BITS-1:0] LAST_CNT = evat_pkg::DIV_CNT_BITS'(QB - 1);

  logic [DB-1:0]                       rem_r, rem_nxt;
  logic [QB-1:0]                       dv_r, dv_nxt;
  logic [DB-1:0]                       den_r, den_nxt;
  logic [evat_pkg::DIV_CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  logic [DB+1:0]                       trial;
  logic                                ge;

  // trial subtract of the shifted remainder
  assign trial = {1'b0, rem_r, dv_r[QB-1]} - {2'b00, den_r};
  assign ge    = ~trial[DB+1];

  always_comb begin
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = DB'(dividend[evat_pkg::DIVIDEND_BITS-1:QB]);
      dv_nxt   = dividend[QB-1:0];
      den_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? trial[DB-1:0] : {rem_r[DB-2:0], dv_r[QB-1]};
      dv_nxt  = {dv_r[QB-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_CNT) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
    den_r <= den_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dv_r;

endmodule

// ----- design/encoder_angle_velocity_tracker_top.sv -----
`timescale 1ns / 1ps
// Flow: a restart or zero-elapsed request goes from idle straight to the output
//   state; a velocity update takes one divider pass first, two with the low-pass.
// Requests: a new one is taken only in idle, once the previous result has been
//   registered for output; the shared divider passes (raw velocity, filter step) set the pace.
// Reset (rst_n, synchronous, active low): turns, angle, velocity, timestamp and
//   filter time clear to zero; no result pending.
// ----------------------------------------------------------------------------
// encoder_angle_velocity_tracker_top
// Multi-turn angle unwrap with velocity estimate and optional first-order
// low-pass, sequenced over one shared serial divider.
// ----------------------------------------------------------------------------
`include "encoder_angle_velocity_tracker_top_defines.svh"

module encoder_angle_velocity_tracker_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input stream
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [evat_pkg::IN_TDATA_BITS-1:0]     in_tdata,   // angle_word[15:0], timestamp_ms[47:16]
  input  logic                                   in_tuser,   // cmd[0]
  // result stream
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [evat_pkg::OUT_TDATA_BITS-1:0]    out_tdata,  // raw_angle[11:0], turn_count[35:12],
                                                             // position_counts[71:36],
                                                             // velocity_q8[101:72], zero[103:102]
  output logic                                   out_tuser,  // velocity_updated[0]
  // filter time register
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [evat_pkg::FT_BITS-1:0]           cfg_data
);

  localparam int AB  = evat_pkg::ANGLE_BITS;
  localparam int TB  = evat_pkg::TURN_BITS;
  localparam int VB  = evat_pkg::VEL_BITS;
  localparam int QB  = evat_pkg::QUOT_BITS;
  localparam int DLB = evat_pkg::DELTA_BITS;
  localparam int SB  = evat_pkg::TS_BITS;
  localparam int DVB = evat_pkg::DIVIDEND_BITS;
  localparam int DSB = evat_pkg::DIVISOR_BITS;
  localparam int MPB = evat_pkg::MSP_BITS;
  localparam logic signed [DLB-1:0] HALF_S = DLB'(evat_pkg::HALF_TURN);
  localparam logic signed [DLB-1:0] FULL_S = DLB'(evat_pkg::FULL_TURN);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV1 = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_DIV2 = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [AB-1:0]           prev_r, prev_nxt;
  logic [TB-1:0]           turns_r, turns_nxt;
  logic [VB-1:0]           vel_r, vel_nxt;
  logic [SB-1:0]           last_r, last_nxt;
  logic [evat_pkg::FT_BITS-1:0] ftm_r;
  logic                    upd_r, upd_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [evat_pkg::OUT_TDATA_BITS-1:0] out_data_r, out_data_nxt;
  logic                    out_user_r, out_user_nxt;
  // working registers
  logic [AB-1:0]           raw_r, raw_nxt;
  logic [SB-1:0]           dt_r, dt_nxt;
  logic                    neg_r, neg_nxt;
  logic [VB-1:0]           dmag_r, dmag_nxt;
  logic                    dneg_r, dneg_nxt;

  // request decode
  logic                    in_req;
  logic                    cmd_in;
  logic [AB-1:0]           raw_in;
  logic [SB-1:0]           now_in;
  logic [SB-1:0]           dt_in;
  logic signed [DLB-1:0]   d_raw, d_corr;
  logic [TB-1:0]           turns_step;
  logic [AB-1:0]           d_mag;
  logic [MPB-1:0]          ms_prod;
  logic [evat_pkg::NUM_BITS-1:0] num_mag;

  // divider hookup
  logic                    div_start;
  logic [DVB-1:0]          div_dividend;
  logic [DSB-1:0]          div_divisor;
  evat_pkg::div_stat_t     div_stat;
  logic [QB-1:0]           div_quot;
  logic [QB-1:0]           q_signed;
  logic [QB-1:0]           diff;
  logic [DVB-1:0]          prod;
  logic [DSB-1:0]          den;

  assign in_tready = (state_r == ST_IDLE);
  assign in_req    = in_tvalid & in_tready;
  assign cmd_in    = in_tuser;
  assign raw_in    = in_tdata[AB-1:0];
  assign now_in    = in_tdata[evat_pkg::WORD_BITS +: SB];
  assign dt_in     = now_in - last_r;

  // half-turn wrap detection; exactly half a turn is no wrap
  always_comb begin
    d_raw = $signed(DLB'(raw_in)) - $signed(DLB'(prev_r));
    if (d_raw > HALF_S) begin
      d_corr     = d_raw - FULL_S;
      turns_step = turns_r - 1'b1;
    end else if (d_raw < -HALF_S) begin
      d_corr     = d_raw + FULL_S;
      turns_step = turns_r + 1'b1;
    end else begin
      d_corr     = d_raw;
      turns_step = turns_r;
    end
  end

  // |delta| * 1000 * 2^frac, below 2^29 so the raw velocity never saturates
  assign d_mag   = d_corr[DLB-1] ? AB'(-d_corr) : AB'(d_corr);
  assign ms_prod = MPB'(d_mag) * MPB'(evat_pkg::MS_PER_S);
  assign num_mag = {ms_prod, {evat_pkg::VEL_FRAC_BITS{1'b0}}};

  // signed quotient and filter difference
  assign q_signed = (state_r == ST_DIV1 ? neg_r : dneg_r) ? (QB'(0) - div_quot) : div_quot;
  assign diff     = q_signed - {vel_r[VB-1], vel_r};
  assign prod     = DVB'(dmag_r) * DVB'(dt_r);
  assign den      = DSB'(ftm_r) + DSB'(dt_r);

  // divider operand select
  assign div_start    = (in_req && !cmd_in && (dt_in != '0)) || (state_r == ST_MUL);
  assign div_dividend = (state_r == ST_MUL) ? prod : DVB'(num_mag);
  assign div_divisor  = (state_r == ST_MUL) ? den : {1'b0, dt_in};

  evat_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    prev_nxt      = prev_r;
    turns_nxt     = turns_r;
    vel_nxt       = vel_r;
    last_nxt      = last_r;
    upd_nxt       = upd_r;
    raw_nxt       = raw_r;
    dt_nxt        = dt_r;
    neg_nxt       = neg_r;
    dmag_nxt      = dmag_r;
    dneg_nxt      = dneg_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_req) begin
          raw_nxt  = raw_in;
          prev_nxt = raw_in;
          upd_nxt  = 1'b0;
          if (cmd_in) begin
            // restart: sample becomes the first read
            turns_nxt = '0;
            vel_nxt   = '0;
            last_nxt  = now_in;
            state_nxt = ST_OUT;
          end else begin
            turns_nxt = turns_step;
            if (dt_in == '0) begin
              state_nxt = ST_OUT;
            end else begin
              last_nxt  = now_in;
              dt_nxt    = dt_in;
              neg_nxt   = d_corr[DLB-1];
              upd_nxt   = 1'b1;
              state_nxt = ST_DIV1;
            end
          end
        end
      end
      ST_DIV1: begin
        if (div_stat.done) begin
          if (ftm_r == '0) begin
            vel_nxt   = q_signed[VB-1:0];
            state_nxt = ST_OUT;
          end else begin
            dneg_nxt  = diff[QB-1];
            dmag_nxt  = diff[QB-1] ? VB'(QB'(0) - diff) : diff[VB-1:0];
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIV2;
      end
      ST_DIV2: begin
        if (div_stat.done) begin
          vel_nxt   = vel_r + q_signed[VB-1:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{evat_pkg::OUT_PAD_BITS{1'b0}}, vel_r, turns_r, raw_r, turns_r, raw_r};
          out_user_nxt  = upd_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and tracked state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_r      <= '0;
      turns_r     <= '0;
      vel_r       <= '0;
      last_r      <= '0;
      ftm_r       <= '0;
      upd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      turns_r     <= turns_nxt;
      vel_r       <= vel_nxt;
      last_r      <= last_nxt;
      upd_r       <= upd_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        ftm_r <= cfg_data;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    raw_r      <= raw_nxt;
    dt_r       <= dt_nxt;
    neg_r      <= neg_nxt;
    dmag_r     <= dmag_nxt;
    dneg_r     <= dneg_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // checks
  `EVAT_ASSERT_NEVER(a_ready_while_div, in_tready && div_stat.busy, "request taken while divider busy")
  `EVAT_ASSERT(a_done_in_div, div_stat.done |-> (state_r == ST_DIV1 || state_r == ST_DIV2), "divider done outside a divide state")
  `EVAT_ASSERT(a_done_after_busy, div_stat.done |-> $past(div_stat.busy), "divider done without a pass")
  `EVAT_ASSERT(a_restart_direct, (in_req && cmd_in) |=> (state_r == ST_OUT && !upd_r), "restart went through the divider")

endmodule

// ----- dv/tb_encoder_angle_velocity_tracker_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_encoder_angle_velocity_tracker_top
// Self-checking bench for the multi-turn angle tracker. Samples are driven as
// smooth encoder motion with random speed, mixed with restarts, zero and huge
// elapsed times and noise. Both streams idle at random. A scoreboard predicts
// turn count, position and (optionally low-passed) velocity per request and
// checks every result in order. The filter time is swept over several phases.
// ----------------------------------------------------------------------------
module tb_encoder_angle_velocity_tracker_top;
  import evat_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 280;
  localparam int IDLE_PCT       = 22;

  typedef struct {
    logic [ANGLE_BITS-1:0] angle;
    logic [TURN_BITS-1:0]  turns;
    logic [POS_BITS-1:0]   position;
    logic [VEL_BITS-1:0]   velocity;
    logic                  updated;
  } sample_result_t;

  // predicts the tracker and keeps the results still owed by the block
  class TrackerScoreboard;
    logic [FT_BITS-1:0]    filter_ms;
    logic [ANGLE_BITS-1:0] last_angle;
    logic [TURN_BITS-1:0]  turn_count;
    longint                velocity;
    logic [TS_BITS-1:0]    last_stamp;
    sample_result_t        expected_results[$];
    int                    errors;

    function new();
      filter_ms  = '0;
      last_angle = '0;
      turn_count = '0;
      velocity   = 0;
      last_stamp = '0;
      errors     = 0;
    endfunction

    function void set_filter(logic [FT_BITS-1:0] value);
      filter_ms = value;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // one accepted request: update state and queue its result
    function void note_request(bit restart, logic [WORD_BITS-1:0] word,
                               logic [TS_BITS-1:0] stamp);
      logic [ANGLE_BITS-1:0] raw;
      logic [TS_BITS-1:0]    dt;
      int                    delta;
      longint                vraw;
      longint                diff;
      sample_result_t        r;
      raw       = word[ANGLE_BITS-1:0];
      r.updated = 1'b0;
      if (restart) begin
        turn_count = '0;
        velocity   = 0;
        last_angle = raw;
        last_stamp = stamp;
      end else begin
        delta = int'(raw) - int'(last_angle);
        // more than half a turn means the angle wrapped
        if (delta > HALF_TURN) begin
          turn_count = turn_count - 1'b1;
          delta      = delta - FULL_TURN;
        end else if (delta < -HALF_TURN) begin
          turn_count = turn_count + 1'b1;
          delta      = delta + FULL_TURN;
        end
        last_angle = raw;
        dt = stamp - last_stamp;
        // no time elapsed: hold velocity and stamp
        if (dt != '0) begin
          vraw = (longint'(delta) * MS_PER_S * (longint'(1) << VEL_FRAC_BITS))
                 / longint'(dt);
          if (vraw > longint'(536870911)) vraw = 536870911;
          if (vraw < longint'(-536870912)) vraw = -536870912;
          if (filter_ms == '0) begin
            velocity = vraw;
          end else begin
            diff     = vraw - velocity;
            velocity = velocity + (diff * longint'(dt))
                       / (longint'(filter_ms) + longint'(dt));
          end
          last_stamp = stamp;
          r.updated  = 1'b1;
        end
      end
      r.angle    = raw;
      r.turns    = turn_count;
      r.position = {turn_count, raw};
      r.velocity = velocity[VEL_BITS-1:0];
      expected_results.push_back(r);
    endfunction

    function void compare(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
    endfunction

    // one accepted result against the oldest expectation
    function void check_result(logic [OUT_TDATA_BITS-1:0] data, logic updated);
      sample_result_t r;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding, actual data 0x%0h",
                 $time, data);
        return;
      end
      r = expected_results.pop_front();
      compare("raw_angle", r.angle, data[ANGLE_BITS-1:0]);
      compare("turn_count", r.turns, data[ANGLE_BITS+TURN_BITS-1:ANGLE_BITS]);
      compare("position_counts", r.position,
              data[ANGLE_BITS+TURN_BITS+POS_BITS-1:ANGLE_BITS+TURN_BITS]);
      compare("velocity_q8", r.velocity,
              data[ANGLE_BITS+TURN_BITS+POS_BITS+VEL_BITS-1:ANGLE_BITS+TURN_BITS+POS_BITS]);
      compare("velocity_updated", r.updated, updated);
    endfunction
  endclass

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [IN_TDATA_BITS-1:0]  in_tdata   = '0;   // angle_word[15:0], timestamp_ms[47:16]
  logic                      in_tuser   = 1'b0; // cmd[0]
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] out_tdata;         // raw_angle, turn_count, position, velocity
  logic                      out_tuser;         // velocity_updated[0]
  logic                      cfg_valid  = 1'b0;
  logic                      cfg_ready;
  logic [FT_BITS-1:0]        cfg_data   = '0;

  TrackerScoreboard sb;
  int               stall_cycles = 0;
  bit               calm = 1'b0;

  // encoder motion model for the random part
  int                 stream_angle = 0;
  int                 stream_speed = 0;
  logic [TS_BITS-1:0] stream_ts    = '0;

  encoder_angle_velocity_tracker_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side backpressure
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // monitors on all three channels, plus the no-progress counter
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    if (rst_n && in_tvalid && in_tready)
      sb.note_request(in_tuser, in_tdata[WORD_BITS-1:0], in_tdata[IN_TDATA_BITS-1:WORD_BITS]);
    if (rst_n && cfg_valid && cfg_ready) sb.set_filter(cfg_data);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  // watchdog
  initial begin
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("tb_encoder_angle_velocity_tracker_top: FAIL");
    $finish;
  end

  // one sample request, with an optional idle gap ahead of it
  task automatic send_sample(input bit restart, input logic [WORD_BITS-1:0] word,
                             input logic [TS_BITS-1:0] stamp);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 72)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {stamp, word};
    in_tuser  <= restart;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // mostly smooth motion, some restarts, stalls in time, jumps and noise
  task automatic send_random_sample();
    int                 pick;
    bit                 restart;
    logic [TS_BITS-1:0] dt;
    pick    = $urandom_range(0, 99);
    restart = 1'b0;
    if (pick < 3) begin
      restart      = 1'b1;
      stream_ts    = $urandom;
      stream_angle = $urandom_range(0, FULL_TURN - 1);
      stream_speed = int'($urandom_range(0, 200)) - 100;
    end else if (pick < 8) begin
      stream_ts    = $urandom;
      stream_angle = $urandom_range(0, FULL_TURN - 1);
    end else if (pick < 11) begin
      // same timestamp again
      stream_angle = stream_angle + int'($urandom_range(0, 40)) - 20;
    end else if (pick < 14) begin
      dt           = $urandom;
      stream_ts    = stream_ts + dt;
      stream_angle = stream_angle + int'($urandom_range(0, FULL_TURN - 1));
    end else begin
      if ($urandom_range(0, 19) == 0) stream_speed = int'($urandom_range(0, 200)) - 100;
      dt           = $urandom_range(1, 20);
      stream_ts    = stream_ts + dt;
      stream_angle = stream_angle + stream_speed * int'(dt) + int'($urandom_range(0, 6)) - 3;
    end
    stream_angle = stream_angle & (FULL_TURN - 1);
    send_sample(restart, {4'($urandom), 12'(stream_angle)}, stream_ts);
  endtask

  // stop sending and wait for every owed result
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_filter(input logic [FT_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input logic [FT_BITS-1:0] filter_value, input bit quiet_run);
    write_filter(filter_value);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      calm = quiet_run && (i >= 60) && (i < 220);
      send_random_sample();
    end
    calm = 1'b0;
    drain();
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: unfiltered edge cases
    write_filter('0);
    send_sample(1'b0, 16'h0000, 32'd0);          // zero elapsed time from reset
    send_sample(1'b1, 16'hF123, 32'd100);        // restart, upper bits masked
    send_sample(1'b0, 16'h0923, 32'd101);        // exactly +half turn
    send_sample(1'b0, 16'h0123, 32'd102);        // exactly -half turn
    send_sample(1'b0, 16'h0924, 32'd103);        // backward wrap
    send_sample(1'b0, 16'h0123, 32'd104);        // forward wrap
    send_sample(1'b0, 16'h0FFF, 32'd104);        // wrap with zero elapsed time
    send_sample(1'b0, 16'h0000, 32'hFFFF_FFFF);  // huge elapsed time
    send_sample(1'b0, 16'h0001, 32'h0000_0003);  // timestamp wraps
    send_sample(1'b0, 16'hFFFF, 32'h0000_0004);  // all word bits set
    send_sample(1'b1, 16'h0000, 32'hFFFF_FFFF);
    send_sample(1'b0, 16'h0800, 32'h0000_0000);  // fastest step, dt of one
    send_sample(1'b0, 16'h0F00, 32'd1);
    send_sample(1'b0, 16'h0700, 32'd2);
    send_sample(1'b0, 16'h0E00, 32'd3);
    send_sample(1'b0, 16'h0500, 32'd4);
    send_sample(1'b0, 16'h0C00, 32'd5);
    send_sample(1'b0, 16'h0400, 32'd6);
    drain();

    // directed: slowest filter, then the fastest
    write_filter(16'hFFFF);
    send_sample(1'b1, 16'h0100, 32'd10);
    send_sample(1'b0, 16'h0900, 32'd11);
    send_sample(1'b0, 16'h0100, 32'hFFFF_FFFF);
    drain();
    write_filter(16'h0001);
    send_sample(1'b0, 16'h0900, 32'd0);
    send_sample(1'b0, 16'h0100, 32'd1);
    send_sample(1'b0, 16'h0200, 32'd3);
    drain();

    // random phases across filter settings
    random_phase(16'h0000, 1'b0);
    random_phase(16'hFFFF, 1'b0);
    random_phase(16'h0001, 1'b1);
    random_phase(16'($urandom_range(2, 50)), 1'b0);
    random_phase(16'($urandom), 1'b0);

    repeat (80) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_encoder_angle_velocity_tracker_top: PASS");
    else
      $display("tb_encoder_angle_velocity_tracker_top: FAIL");
    $finish;
  end

endmodule
